@@ hw/rtl/vertex_transform_clip_project_top_assert.svh @@
// assertion macros used by the checker module
`ifndef VERTEX_TRANSFORM_CLIP_PROJECT_TOP_ASSERT_SVH
`define VERTEX_TRANSFORM_CLIP_PROJECT_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define VTCP_ASSERT_NOW(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("assertion failed");

// condition implies consequence in the next cycle
`define VTCP_ASSERT_NEXT(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hw/rtl/vtcp_pkg.sv @@
package vtcp_pkg;

	// coordinate word width, fixed by the payload format
	localparam int CW = 32;
	localparam int SW = 2 * CW + 2;
	localparam int DEF_FRAC_BITS = 16;
	localparam int AW = 5;

	localparam logic signed [CW-1:0] MAX_CW = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] MIN_CW = {1'b1, {(CW-1){1'b0}}};

	// commands
	localparam logic [1:0] CMD_LOAD       = 2'd0;
	localparam logic [1:0] CMD_XFORM      = 2'd1;
	localparam logic [1:0] CMD_XFORM_CLIP = 2'd2;
	// reserved code, dropped without a result
	localparam logic [1:0] CMD_RSVD       = 2'd3;

	// register indexes
	localparam logic [2:0] REG_SCALE_X = 3'd0;
	localparam logic [2:0] REG_SCALE_Y = 3'd1;
	localparam logic [2:0] REG_SHIFT_X = 3'd2;
	localparam logic [2:0] REG_SHIFT_Y = 3'd3;
	localparam logic [2:0] REG_NEAR    = 3'd4;

	// outcode bits
	localparam int OC_NEAR   = 0;
	localparam int OC_TOP    = 1;
	localparam int OC_BOTTOM = 2;
	localparam int OC_LEFT   = 3;
	localparam int OC_RIGHT  = 4;

	typedef struct packed {
		logic [1:0]           command;
		logic [3:0]           coeff_index;
		logic signed [CW-1:0] coeff_value;
		logic signed [CW-1:0] pos_x;
		logic signed [CW-1:0] pos_y;
		logic signed [CW-1:0] pos_z;
		logic                 batch_end;
	} vtx_in_t;

	typedef struct packed {
		logic signed [CW-1:0] pixel_x;
		logic signed [CW-1:0] pixel_y;
		logic signed [CW-1:0] depth;
		logic signed [CW-1:0] cam_right;
		logic signed [CW-1:0] cam_down;
		logic [4:0]           clip_bits;
		logic                 clip_valid;
		logic                 divide_fault;
		logic                 batch_end_res;
	} vtx_out_t;

	// per-vertex sideband carried down the divider pipeline
	typedef struct packed {
		logic                 with_clip;
		logic                 batch_end;
		logic                 fault;
		logic [4:0]           clip;
		logic signed [CW-1:0] z;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
	} side_t;

	// saturate a wide signed value to one coordinate word
	function automatic logic signed [CW-1:0] sat_cw(input logic signed [SW-1:0] a);
		logic [SW-CW:0] top;
		top = a[SW-1:CW-1];
		if (top == '0 || top == '1) begin
			return a[CW-1:0];
		end
		return a[SW-1] ? MIN_CW : MAX_CW;
	endfunction

endpackage

@@ hw/rtl/vertex_transform_clip_project_top.sv @@
// Vertex transform, outcode clip and perspective projection, Q(CW-FRAC_BITS).FRAC_BITS.
// Vertex channel: vtx_valid / vtx_ready with payload vtx. Load commands write one
// rotation or translation coefficient at acceptance and give no result; transform
// commands give one item on the result channel res_valid / res_ready / res.
// Scale, shift and near limit sit on the APB port (pready tied high); the user
// must write them only while the block is idle, which the block does not enforce.
// Throughput: one vertex per cycle, every cycle, when the receiver keeps up.
// A vertex passes the product, row-sum and outcode stages, the restoring divider,
// then the quotient, scale and output registers; at Q16.16 the divider resolves one
// quotient bit per stage over the CW + FRAC_BITS bits of the shifted numerator.
// Each stage holds its item and valid bit; a stalled receiver backs pressure up
// stage by stage, so bubbles collapse and new vertices are still taken while
// the output register waits. Loads are taken whenever vtx_ready is high.
// Reset clears all valid bits, the matrix and translation to zero, scale to
// 1.0, shift to 0 and near limit to 1.0.
module vertex_transform_clip_project_top
	import vtcp_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vtx_valid,
	output logic            vtx_ready,
	input  vtx_in_t         vtx,
	output logic            res_valid,
	input  logic            res_ready,
	output vtx_out_t        res,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [AW-1:0]   paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready
);

	localparam int DW     = CW + FRAC_BITS;
	localparam int IDX_D0 = 3;
	localparam int IDX_SQ = IDX_D0 + DW;
	localparam int IDX_SM = IDX_SQ + 1;
	localparam int IDX_SO = IDX_SQ + 2;
	localparam int NS     = IDX_SO + 1;

	// configuration and coefficient registers
	logic signed [CW-1:0] scale_x_q, scale_y_q, shift_x_q, shift_y_q;
	logic [CW-2:0]        near_q;
	logic signed [CW-1:0] mat_q [9];
	logic signed [CW-1:0] trn_q [3];

	// pipeline control
	logic [NS-1:0] vld_q;
	logic [NS:0]   adv;
	logic          vtx_acc;

	// stage registers
	logic signed [2*CW-1:0] prod_s1 [9];
	logic signed [CW-1:0]   trn_s1 [3];
	logic                   wc_s1, be_s1;
	logic signed [CW-1:0]   zxy_s2 [3];
	logic                   wc_s2, be_s2;
	side_t                  side_s3;
	logic [CW-1:0]          magx_s3, magy_s3;
	side_t                  side_sd [DW];
	logic [CW-2:0]          remx_sd [DW];
	logic [CW-2:0]          remy_sd [DW];
	logic [DW-1:0]          nqx_sd [DW];
	logic [DW-1:0]          nqy_sd [DW];
	side_t                  side_sq;
	logic signed [CW-1:0]   qx_sq, qy_sq;
	side_t                  side_sm;
	logic signed [2*CW-1:0] mx_sm, my_sm;
	vtx_out_t               out_so;

	// combinational stage results
	logic signed [CW-1:0]   pos [3];
	logic signed [2*CW-1:0] prod_c [9];
	logic signed [SW-1:0]   dot_c [3];
	logic signed [CW-1:0]   zxy_c [3];
	logic [4:0]             clip_c;
	logic signed [CW:0]     nz_c;
	logic signed [CW-1:0]   qx_c, qy_c, px_c, py_c;
	vtx_out_t               out_c;

	// apb register port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q <= CW'(1) <<< FRAC_BITS;
			scale_y_q <= CW'(1) <<< FRAC_BITS;
			shift_x_q <= '0;
			shift_y_q <= '0;
			near_q    <= (CW-1)'(1) << FRAC_BITS;
		end else if (psel && penable && pwrite) begin
			case (paddr[AW-1:2])
				REG_SCALE_X: scale_x_q <= pwdata[CW-1:0];
				REG_SCALE_Y: scale_y_q <= pwdata[CW-1:0];
				REG_SHIFT_X: shift_x_q <= pwdata[CW-1:0];
				REG_SHIFT_Y: shift_y_q <= pwdata[CW-1:0];
				REG_NEAR:    near_q    <= pwdata[CW-2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[AW-1:2])
			REG_SCALE_X: prdata = scale_x_q;
			REG_SCALE_Y: prdata = scale_y_q;
			REG_SHIFT_X: prdata = shift_x_q;
			REG_SHIFT_Y: prdata = shift_y_q;
			REG_NEAR:    prdata = {1'b0, near_q};
			default:     prdata = '0;
		endcase
	end

	// coefficient loads take effect at acceptance
	assign vtx_acc = vtx_valid && vtx_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) mat_q[i] <= '0;
			for (int i = 0; i < 3; i++) trn_q[i] <= '0;
		end else if (vtx_acc && vtx.command == CMD_LOAD) begin
			for (int i = 0; i < 9; i++) begin
				if (vtx.coeff_index == 4'(i)) mat_q[i] <= vtx.coeff_value;
			end
			for (int i = 0; i < 3; i++) begin
				if (vtx.coeff_index == 4'(i + 9)) trn_q[i] <= vtx.coeff_value;
			end
		end
	end

	// ready chain: a stage moves when empty or when the next one moves
	always_comb begin
		adv[NS] = res_ready;
		for (int k = NS - 1; k >= 0; k--) adv[k] = !vld_q[k] || adv[k+1];
	end
	assign vtx_ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= vtx_acc && (vtx.command == CMD_XFORM ||
					vtx.command == CMD_XFORM_CLIP);
			end
			for (int k = 1; k < NS; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// stage 1: nine products
	assign pos[0] = vtx.pos_x;
	assign pos[1] = vtx.pos_y;
	assign pos[2] = vtx.pos_z;

	always_comb begin
		for (int i = 0; i < 9; i++) prod_c[i] = mat_q[i] * pos[i % 3];
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			prod_s1 <= prod_c;
			trn_s1  <= trn_q;
			wc_s1   <= (vtx.command == CMD_XFORM_CLIP);
			be_s1   <= vtx.batch_end;
		end
	end

	// stage 2: row sums, floor shift, translation, saturate
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			dot_c[r] = ((SW'(prod_s1[3*r]) + SW'(prod_s1[3*r+1]) + SW'(prod_s1[3*r+2]))
				>>> FRAC_BITS) + SW'(trn_s1[r]);
			zxy_c[r] = sat_cw(dot_c[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			zxy_s2 <= zxy_c;
			wc_s2  <= wc_s1;
			be_s2  <= be_s1;
		end
	end

	// stage 3: outcodes, fault, magnitudes for the divider
	always_comb begin
		clip_c = '0;
		nz_c   = -(CW+1)'(zxy_s2[0]);
		if (wc_s2) begin
			clip_c[OC_NEAR] = zxy_s2[0] < $signed({1'b0, near_q});
			if (zxy_s2[2] > zxy_s2[0] || zxy_s2[0] < 0 || (CW+1)'(zxy_s2[2]) < nz_c) begin
				if (zxy_s2[2] > zxy_s2[0]) clip_c[OC_BOTTOM] = 1'b1;
				else clip_c[OC_TOP] = 1'b1;
			end
			if (zxy_s2[1] > zxy_s2[0] || zxy_s2[0] < 0 || (CW+1)'(zxy_s2[1]) < nz_c) begin
				if (zxy_s2[1] > zxy_s2[0]) clip_c[OC_RIGHT] = 1'b1;
				else clip_c[OC_LEFT] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			side_s3.with_clip <= wc_s2;
			side_s3.batch_end <= be_s2;
			side_s3.fault     <= zxy_s2[0] <= 0;
			side_s3.clip      <= clip_c;
			side_s3.z         <= zxy_s2[0];
			side_s3.x         <= zxy_s2[1];
			side_s3.y         <= zxy_s2[2];
			magx_s3 <= zxy_s2[1][CW-1] ? -zxy_s2[1] : zxy_s2[1];
			magy_s3 <= zxy_s2[2][CW-1] ? -zxy_s2[2] : zxy_s2[2];
		end
	end

	// restoring divider: one quotient bit per stage, both lanes share the depth
	for (genvar j = 0; j < DW; j++) begin : g_div
		side_t         sp;
		logic [CW-2:0] rpx, rpy;
		logic [DW-1:0] npx, npy;
		logic [CW-1:0] rx2, ry2, dx, dy;
		logic          bx, by;

		if (j == 0) begin : g_first
			assign sp  = side_s3;
			assign rpx = '0;
			assign rpy = '0;
			assign npx = {magx_s3, FRAC_BITS'(0)};
			assign npy = {magy_s3, FRAC_BITS'(0)};
		end else begin : g_next
			assign sp  = side_sd[j-1];
			assign rpx = remx_sd[j-1];
			assign rpy = remy_sd[j-1];
			assign npx = nqx_sd[j-1];
			assign npy = nqy_sd[j-1];
		end

		assign rx2 = {rpx, npx[DW-1]};
		assign ry2 = {rpy, npy[DW-1]};
		assign bx  = rx2 >= sp.z;
		assign by  = ry2 >= sp.z;
		assign dx  = rx2 - sp.z;
		assign dy  = ry2 - sp.z;

		always_ff @(posedge clk) begin
			if (adv[IDX_D0 + j]) begin
				side_sd[j] <= sp;
				remx_sd[j] <= bx ? dx[CW-2:0] : rx2[CW-2:0];
				remy_sd[j] <= by ? dy[CW-2:0] : ry2[CW-2:0];
				nqx_sd[j]  <= {npx[DW-2:0], bx};
				nqy_sd[j]  <= {npy[DW-2:0], by};
			end
		end
	end

	// quotient sign and saturation
	always_comb begin
		if (nqx_sd[DW-1][DW-1:CW-1] != '0) qx_c = side_sd[DW-1].x[CW-1] ? MIN_CW : MAX_CW;
		else if (side_sd[DW-1].x[CW-1]) qx_c = -nqx_sd[DW-1][CW-1:0];
		else qx_c = nqx_sd[DW-1][CW-1:0];
		if (nqy_sd[DW-1][DW-1:CW-1] != '0) qy_c = side_sd[DW-1].y[CW-1] ? MIN_CW : MAX_CW;
		else if (side_sd[DW-1].y[CW-1]) qy_c = -nqy_sd[DW-1][CW-1:0];
		else qy_c = nqy_sd[DW-1][CW-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv[IDX_SQ]) begin
			side_sq <= side_sd[DW-1];
			qx_sq   <= qx_c;
			qy_sq   <= qy_c;
		end
	end

	// pixel scale
	always_ff @(posedge clk) begin
		if (adv[IDX_SM]) begin
			side_sm <= side_sq;
			mx_sm   <= qx_sq * scale_x_q;
			my_sm   <= qy_sq * scale_y_q;
		end
	end

	// shift, saturate, fault override, result fields
	always_comb begin
		px_c = sat_cw(SW'(mx_sm >>> FRAC_BITS) + SW'(shift_x_q));
		py_c = sat_cw(SW'(my_sm >>> FRAC_BITS) + SW'(shift_y_q));
		if (side_sm.fault) begin
			px_c = side_sm.x[CW-1] ? MIN_CW : MAX_CW;
			py_c = side_sm.y[CW-1] ? MIN_CW : MAX_CW;
		end
		out_c.pixel_x       = px_c;
		out_c.pixel_y       = py_c;
		out_c.depth         = side_sm.z;
		out_c.cam_right     = side_sm.with_clip ? side_sm.x : '0;
		out_c.cam_down      = side_sm.with_clip ? side_sm.y : '0;
		out_c.clip_bits     = side_sm.clip;
		out_c.clip_valid    = side_sm.with_clip;
		out_c.divide_fault  = side_sm.fault;
		out_c.batch_end_res = side_sm.batch_end;
	end

	always_ff @(posedge clk) begin
		if (adv[IDX_SO]) out_so <= out_c;
	end

	assign res       = out_so;
	assign res_valid = vld_q[IDX_SO];

endmodule

@@ hw/rtl/vtcp_checker.sv @@
`include "vertex_transform_clip_project_top_assert.svh"

module vtcp_checker
	import vtcp_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     res_valid,
	input logic     res_ready,
	input vtx_out_t res
);

	// stalled item holds
	`VTCP_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))

	// fault exactly when depth is not positive
	`VTCP_ASSERT_NOW(a_fault_depth, res_valid, res.divide_fault == (res.depth <= 0))

	// a fault saturates the projection
	`VTCP_ASSERT_NOW(a_fault_sat, res_valid && res.divide_fault, (res.pixel_x == MAX_CW || res.pixel_x == MIN_CW) && (res.pixel_y == MAX_CW || res.pixel_y == MIN_CW))

	// without clipping the camera fields and outcodes are zero
	`VTCP_ASSERT_NOW(a_no_clip, res_valid && !res.clip_valid, res.clip_bits == 5'd0 && res.cam_right == 0 && res.cam_down == 0)

endmodule

bind vertex_transform_clip_project_top vtcp_checker u_vtcp_checker (.*);

@@ bench/tb_vertex_transform_clip_project_top.sv @@
`timescale 1ns / 100ps

module tb_vertex_transform_clip_project_top;
	import vtcp_pkg::*;

	localparam int FB = DEF_FRAC_BITS;
	localparam int LATENCY = 5 + CW + FB;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic vtx_valid;
	logic vtx_ready;
	vtx_in_t vtx;
	logic res_valid;
	logic res_ready;
	vtx_out_t res;
	logic psel;
	logic penable;
	logic pwrite;
	logic [AW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	vertex_transform_clip_project_top u_top (
		.clk(clk), .arst_n(arst_n),
		.vtx_valid(vtx_valid), .vtx_ready(vtx_ready), .vtx(vtx),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	logic signed [CW-1:0] mat [9];
	logic signed [CW-1:0] trans [3];
	logic signed [CW-1:0] sc_x, sc_y, sh_x, sh_y;
	logic [CW-2:0] near_lim;

	vtx_out_t pending_px [$];
	int errors;
	longint cycles;
	bit rx_hold;
	bit no_idle;

	// directed table: item plus optional hand-typed result
	typedef struct {
		vtx_in_t item;
		bit typed;
		vtx_out_t want;
	} row_t;
	row_t rows [$];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout at %0t", $time);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	function automatic logic signed [CW-1:0] sat_word(input logic signed [159:0] a);
		logic signed [159:0] hi, lo;
		hi = 160'sd2147483647;
		lo = -160'sd2147483648;
		if (a > hi) return MAX_CW;
		if (a < lo) return MIN_CW;
		return a[CW-1:0];
	endfunction

	// exact row product, floor shift, saturate
	function automatic logic signed [CW-1:0] row_dot(input int r,
			input logic signed [CW-1:0] p [3]);
		logic signed [159:0] acc;
		acc = 0;
		for (int i = 0; i < 3; i++)
			acc += 160'(mat[r*3+i]) * 160'(p[i]);
		acc = (acc >>> FB) + 160'(trans[r]);
		return sat_word(acc);
	endfunction

	function automatic logic signed [CW-1:0] pixel_of(input logic signed [CW-1:0] c,
			input logic signed [CW-1:0] z, input logic signed [CW-1:0] s,
			input logic signed [CW-1:0] sh);
		logic signed [159:0] n, q, v;
		logic [159:0] mg;
		logic signed [CW-1:0] qs;
		n = 160'(c);
		mg = n < 0 ? 160'(-n) : 160'(n);
		mg = (mg << FB) / 160'(z);
		q = n < 0 ? -$signed(mg) : $signed(mg);
		qs = sat_word(q);
		v = ((160'(qs) * 160'(s)) >>> FB) + 160'(sh);
		return sat_word(v);
	endfunction

	// returns 1 when a result is due
	function automatic bit predict_vertex(input vtx_in_t it, output vtx_out_t o);
		logic signed [CW-1:0] p [3];
		logic signed [CW-1:0] z, x, y;
		logic [4:0] cb;
		bit clip_on;
		o = '0;
		if (it.command == CMD_LOAD) begin
			if (it.coeff_index < 9) mat[it.coeff_index] = it.coeff_value;
			else if (it.coeff_index < 12) trans[it.coeff_index - 9] = it.coeff_value;
			return 0;
		end
		if (it.command != CMD_XFORM && it.command != CMD_XFORM_CLIP) return 0;
		clip_on = (it.command == CMD_XFORM_CLIP);
		p[0] = it.pos_x;
		p[1] = it.pos_y;
		p[2] = it.pos_z;
		z = row_dot(0, p);
		x = row_dot(1, p);
		y = row_dot(2, p);
		cb = '0;
		if (clip_on) begin
			if (64'(z) < $signed({33'd0, near_lim})) cb[OC_NEAR] = 1'b1;
			if (y > z || z < 0 || 64'(y) < -64'(z))
				cb[(y > z) ? OC_BOTTOM : OC_TOP] = 1'b1;
			if (x > z || z < 0 || 64'(x) < -64'(z))
				cb[(x > z) ? OC_RIGHT : OC_LEFT] = 1'b1;
		end
		if (z <= 0) begin
			o.divide_fault = 1'b1;
			o.pixel_x = x >= 0 ? MAX_CW : MIN_CW;
			o.pixel_y = y >= 0 ? MAX_CW : MIN_CW;
		end else begin
			o.pixel_x = pixel_of(x, z, sc_x, sh_x);
			o.pixel_y = pixel_of(y, z, sc_y, sh_y);
		end
		o.depth = z;
		o.cam_right = clip_on ? x : '0;
		o.cam_down = clip_on ? y : '0;
		o.clip_bits = cb;
		o.clip_valid = clip_on;
		o.batch_end_res = it.batch_end;
		return 1;
	endfunction

	// apb write, both phases; the port stays selected until the caller lets go
	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= AW'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_SCALE_X: sc_x = val;
			REG_SCALE_Y: sc_y = val;
			REG_SHIFT_X: sh_x = val;
			REG_SHIFT_Y: sh_y = val;
			REG_NEAR:    near_lim = val[CW-2:0];
			default: ;
		endcase
	endtask

	// wait for all results plus the drain of load-only work
	task automatic drain_wait();
		vtx_valid <= 1'b0;
		while (pending_px.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// offer one item until accepted, with random gaps
	task automatic send_item(input vtx_in_t it, input bit typed, input vtx_out_t want);
		vtx_out_t o;
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			vtx_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		vtx_valid <= 1'b1;
		vtx <= it;
		@(posedge clk);
		while (!vtx_ready) @(posedge clk);
		if (predict_vertex(it, o)) begin
			if (typed) o = want;
			pending_px.push_back(o);
		end
	endtask

	// receiver side idling and check
	initial begin
		res_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold) begin
				res_ready <= 1'b0;
				@(posedge clk);
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				res_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (pending_px.size() == 0) begin
				$display("%0t: unexpected result %h", $time, res);
				errors++;
			end else begin
				vtx_out_t e;
				e = pending_px.pop_front();
				if (e.pixel_x !== res.pixel_x)
					$display("%0t: pixel_x exp %h got %h", $time, e.pixel_x, res.pixel_x);
				if (e.pixel_y !== res.pixel_y)
					$display("%0t: pixel_y exp %h got %h", $time, e.pixel_y, res.pixel_y);
				if (e.depth !== res.depth)
					$display("%0t: depth exp %h got %h", $time, e.depth, res.depth);
				if (e.cam_right !== res.cam_right)
					$display("%0t: cam_right exp %h got %h", $time, e.cam_right, res.cam_right);
				if (e.cam_down !== res.cam_down)
					$display("%0t: cam_down exp %h got %h", $time, e.cam_down, res.cam_down);
				if (e.clip_bits !== res.clip_bits)
					$display("%0t: clip_bits exp %h got %h", $time, e.clip_bits, res.clip_bits);
				if (e.clip_valid !== res.clip_valid)
					$display("%0t: clip_valid exp %b got %b", $time, e.clip_valid,
						res.clip_valid);
				if (e.divide_fault !== res.divide_fault)
					$display("%0t: divide_fault exp %b got %b", $time, e.divide_fault,
						res.divide_fault);
				if (e.batch_end_res !== res.batch_end_res)
					$display("%0t: batch_end_res exp %b got %b", $time, e.batch_end_res,
						res.batch_end_res);
				if (e !== res) errors++;
			end
		end
	end

	function automatic vtx_in_t load_item(input int idx, input logic [31:0] v);
		vtx_in_t it;
		it = '0;
		it.command = CMD_LOAD;
		it.coeff_index = 4'(idx);
		it.coeff_value = v;
		it.pos_x = $urandom;
		return it;
	endfunction

	function automatic vtx_in_t xform_item(input logic [1:0] cmd, input logic [31:0] px,
			input logic [31:0] py, input logic [31:0] pz, input bit be);
		vtx_in_t it;
		it = '0;
		it.command = cmd;
		it.coeff_index = 4'($urandom);
		it.coeff_value = $urandom;
		it.pos_x = px;
		it.pos_y = py;
		it.pos_z = pz;
		it.batch_end = be;
		return it;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			2: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
			default: return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
		endcase
	endfunction

	// fill the matrix and translation with a plausible random camera
	task automatic load_camera();
		for (int i = 0; i < 12; i++) begin
			logic [31:0] v;
			if ($urandom_range(0, 9) == 0) v = $urandom;
			else if (i >= 9) v = i == 9 ? $urandom_range(0, 300 << 16) :
				32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
			else v = 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
			send_item(load_item(i, v), 0, '0);
		end
	endtask

	task automatic rand_phase(input int n);
		vtx_in_t it;
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 19);
			if (k == 0) load_camera();
			if (k == 1) it = load_item($urandom_range(0, 15), $urandom);
			else if (k == 2) it = xform_item(CMD_RSVD, $urandom, $urandom, $urandom,
				1'($urandom));
			else it = xform_item($urandom_range(0, 1) ? CMD_XFORM_CLIP : CMD_XFORM,
				rand_coord(), rand_coord(), rand_coord(), 1'($urandom));
			send_item(it, 0, '0);
		end
	endtask

	initial begin
		vtx_out_t w;
		errors = 0;
		rx_hold = 0;
		no_idle = 0;
		arst_n = 1'b0;
		vtx_valid = 1'b0;
		vtx = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		for (int i = 0; i < 9; i++) mat[i] = '0;
		for (int i = 0; i < 3; i++) trans[i] = '0;
		sc_x = 32'sh10000;
		sc_y = 32'sh10000;
		sh_x = '0;
		sh_y = '0;
		near_lim = 31'h10000;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset the matrix is zero: depth 0, fault, saturated high
		w = '0;
		w.pixel_x = MAX_CW;
		w.pixel_y = MAX_CW;
		w.divide_fault = 1'b1;
		w.batch_end_res = 1'b1;
		rows.push_back('{xform_item(CMD_XFORM, 32'h7fffffff, 32'h80000000, '1, 1'b1), 1, w});
		w.batch_end_res = 1'b0;
		w.clip_valid = 1'b1;
		w.clip_bits = 5'b00001;
		rows.push_back('{xform_item(CMD_XFORM_CLIP, '0, '0, '0, 1'b0), 1, w});
		w.batch_end_res = 1'b1;
		rows.push_back('{xform_item(CMD_XFORM_CLIP, '1, '1, '1, 1'b1), 1, w});
		// ignored command and index
		rows.push_back('{xform_item(CMD_RSVD, '1, '1, '1, 1'b1), 0, '0});
		rows.push_back('{load_item(12, '1), 0, '0});
		rows.push_back('{load_item(15, '1), 0, '0});
		// identity camera at depth 10
		rows.push_back('{load_item(0, 32'h10000), 0, '0});
		rows.push_back('{load_item(4, 32'h10000), 0, '0});
		rows.push_back('{load_item(8, 32'h10000), 0, '0});
		rows.push_back('{load_item(9, 32'ha0000), 0, '0});
		rows.push_back('{xform_item(CMD_XFORM_CLIP, '0, 32'h20000, 32'hfffd0000, 1'b1),
			0, '0});
		rows.push_back('{xform_item(CMD_XFORM_CLIP, '0, 32'h200000, 32'hffe00000, 1'b0),
			0, '0});
		rows.push_back('{xform_item(CMD_XFORM_CLIP, '0, 32'hffe00000, 32'h200000, 1'b0),
			0, '0});
		rows.push_back('{xform_item(CMD_XFORM, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
			1'b1), 0, '0});
		// depth negative: behind the camera
		rows.push_back('{xform_item(CMD_XFORM_CLIP, 32'hff000000, 32'h10000, 32'hffff0000,
			1'b0), 0, '0});
		// extreme translation terms
		rows.push_back('{load_item(10, 32'h7fffffff), 0, '0});
		rows.push_back('{load_item(11, 32'h80000000), 0, '0});
		rows.push_back('{xform_item(CMD_XFORM_CLIP, 32'h10000, 32'h7fffffff, 32'h7fffffff,
			1'b1), 0, '0});
		rows.push_back('{xform_item(CMD_XFORM, 32'h1, 32'h80000000, 32'h80000000, 1'b0),
			0, '0});
		foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].want);
		drain_wait();

		// settings phases, extremes included
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					reg_write(REG_SCALE_X, 32'd320 << 16);
					reg_write(REG_SCALE_Y, 32'd240 << 16);
					reg_write(REG_SHIFT_X, 32'd320 << 16);
					reg_write(REG_SHIFT_Y, 32'd240 << 16);
					reg_write(REG_NEAR, 32'h8000);
				end
				1: begin
					reg_write(REG_SCALE_X, 32'h7fffffff);
					reg_write(REG_SCALE_Y, 32'h80000000);
					reg_write(REG_SHIFT_X, 32'h80000000);
					reg_write(REG_SHIFT_Y, 32'h7fffffff);
					reg_write(REG_NEAR, 32'h7fffffff);
				end
				2: begin
					reg_write(REG_SCALE_X, '0);
					reg_write(REG_SCALE_Y, '1);
					reg_write(REG_SHIFT_X, '0);
					reg_write(REG_SHIFT_Y, '1);
					reg_write(REG_NEAR, '0);
				end
				default: begin
					reg_write(REG_SCALE_X, $urandom);
					reg_write(REG_SCALE_Y, $urandom);
					reg_write(REG_SHIFT_X, $urandom);
					reg_write(REG_SHIFT_Y, $urandom);
					reg_write(REG_NEAR, $urandom);
				end
			endcase
			psel <= 1'b0;
			penable <= 1'b0;
			pwrite <= 1'b0;
			load_camera();
			if (ph == 1) begin
				// long receiver hold while items keep coming
				rx_hold = 1;
				fork
					begin
						repeat (300) @(posedge clk);
						rx_hold = 0;
					end
					rand_phase(150);
				join
			end else begin
				rand_phase(130);
			end
			if (ph == 5) no_idle = 1;
			if (ph == 5) rand_phase(80);
			drain_wait();
		end

		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
